>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands for the station statistics table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define KSST_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked on every rising edge, reset included.
`define KSST_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> rtl/ksst_pkg.sv
// ----------------------------------------------------------------------------
// ksst_pkg
// Types and constants shared by the station statistics table.
// ----------------------------------------------------------------------------
package ksst_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic               action;
    logic               has_address;
    logic [47:0]        station_address;
    logic [31:0]        name_digest;
    logic [3:0]         auth_code;
    logic [7:0]         radio_channel;
    logic signed [7:0]  signal_level;
  } in_word_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         status;
    logic [4:0]         entry_index;
    logic [15:0]        sample_total;
    logic signed [7:0]  best_level;
    logic [15:0]        overflow_total;
    logic [5:0]         entries_used;
  } out_word_t;

  // Search word travelling down the row of cells.
  typedef struct packed {
    logic               valid;
    logic [47:0]        key;
    logic [31:0]        digest;
    logic [3:0]         auth;
    logic [7:0]         chan;
    logic signed [7:0]  level;
    logic [CNT_W-1:0]   used;
    logic               done;
    logic               ins;
    logic [IDX_W-1:0]   idx;
    logic [15:0]        count;
    logic signed [7:0]  best;
  } probe_t;

endpackage

>>> rtl/ksst_if.sv
// ----------------------------------------------------------------------------
// ksst_in_if / ksst_out_if
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
interface ksst_in_if;
  logic               valid;
  logic               ready;
  ksst_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ksst_out_if;
  logic                valid;
  logic                ready;
  ksst_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ksst_cell.sv
// ----------------------------------------------------------------------------
// ksst_cell
// One table slot: holds an entry, matches, updates or fills it as the
// search word passes, and hands the word on to the next slot.
// ----------------------------------------------------------------------------
module ksst_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ksst_pkg::IDX_W-1:0]    cell_id,
  input  ksst_pkg::probe_t              probe_in,
  output ksst_pkg::probe_t              probe_out
);

  logic [47:0]       key_r;
  logic [31:0]       digest_r;
  logic [3:0]        auth_r;
  logic [7:0]        chan_r;
  logic signed [7:0] best_r;
  logic signed [7:0] last_r;
  logic [15:0]       count_r;

  logic [47:0]       key_nxt;
  logic [31:0]       digest_nxt;
  logic [3:0]        auth_nxt;
  logic [7:0]        chan_nxt;
  logic signed [7:0] best_nxt;
  logic signed [7:0] last_nxt;
  logic [15:0]       count_nxt;

  ksst_pkg::probe_t  probe_r;
  ksst_pkg::probe_t  probe_nxt;

  logic [ksst_pkg::CNT_W-1:0] id_ext;
  logic                       live;
  logic                       hit;
  logic                       ins;

  always_comb begin
    id_ext = ksst_pkg::CNT_W'(cell_id);
    live   = probe_in.valid && !probe_in.done;
    hit    = live && (id_ext < probe_in.used) && (key_r == probe_in.key);
    ins    = live && (id_ext == probe_in.used);

    key_nxt    = key_r;
    digest_nxt = digest_r;
    auth_nxt   = auth_r;
    chan_nxt   = chan_r;
    best_nxt   = best_r;
    last_nxt   = last_r;
    count_nxt  = count_r;
    probe_nxt  = probe_in;

    if (hit) begin
      count_nxt = (count_r == ksst_pkg::COUNT_MAX) ? count_r : count_r + 16'd1;
      last_nxt  = probe_in.level;
      best_nxt  = (probe_in.level > best_r) ? probe_in.level : best_r;
      if (probe_in.digest != 32'd0) begin
        digest_nxt = probe_in.digest;
      end
      if (probe_in.auth != 4'd0) begin
        auth_nxt = probe_in.auth;
      end
      if (probe_in.chan != 8'd0) begin
        chan_nxt = probe_in.chan;
      end
    end else if (ins) begin
      key_nxt    = probe_in.key;
      digest_nxt = probe_in.digest;
      auth_nxt   = probe_in.auth;
      chan_nxt   = probe_in.chan;
      best_nxt   = probe_in.level;
      last_nxt   = probe_in.level;
      count_nxt  = 16'd1;
    end

    if (hit || ins) begin
      probe_nxt.done  = 1'b1;
      probe_nxt.ins   = ins;
      probe_nxt.idx   = cell_id;
      probe_nxt.count = count_nxt;
      probe_nxt.best  = best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    digest_r <= digest_nxt;
    auth_r   <= auth_nxt;
    chan_r   <= chan_nxt;
    best_r   <= best_nxt;
    last_r   <= last_nxt;
    count_r  <= count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign probe_out = probe_r;

endmodule

>>> rtl/keyed_station_stats_table_top.sv
// ----------------------------------------------------------------------------
// keyed_station_stats_table_top
// Access-point statistics table keyed by station address, searched by a
// word that moves through a row of slot cells.
// ----------------------------------------------------------------------------
// An observation's result follows the walk through the head register and the row
// of slot cells, and is then registered for the output.
// Clear and empty-address words are shown 1 cycle after acceptance.
// Throughput: one word at a time; the next is taken the cycle after the
// result is taken.
// Reset: synchronous, active low; entry count and overflow count clear.
module keyed_station_stats_table_top (
  input  logic              clk,
  input  logic              rst_n,
  ksst_in_if.sink           in_ch,
  ksst_out_if.source        out_ch
);

  `include "assert_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BUSY = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [ksst_pkg::CNT_W-1:0]  used_r, used_nxt;
  logic [15:0]                 dropped_r, dropped_nxt;
  ksst_pkg::out_word_t         res_r, res_nxt;
  ksst_pkg::probe_t            head_r, head_nxt;

  ksst_pkg::probe_t            chain [ksst_pkg::TABLE_DEPTH+1];
  ksst_pkg::probe_t            tail;
  logic [ksst_pkg::TABLE_DEPTH:0] probe_vld;

  assign chain[0] = head_r;
  assign tail     = chain[ksst_pkg::TABLE_DEPTH];

  for (genvar g = 0; g < ksst_pkg::TABLE_DEPTH; g++) begin : g_cell
    ksst_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_id   (ksst_pkg::IDX_W'(g)),
      .probe_in  (chain[g]),
      .probe_out (chain[g+1])
    );
  end

  always_comb begin
    for (int k = 0; k <= ksst_pkg::TABLE_DEPTH; k++) begin
      probe_vld[k] = chain[k].valid;
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = res_r;

  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    dropped_nxt = dropped_r;
    res_nxt     = res_r;
    head_nxt    = head_r;
    head_nxt.valid = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_nxt = '0;
          if (in_ch.data.action) begin
            used_nxt       = '0;
            dropped_nxt    = 16'd0;
            res_nxt.status = ksst_pkg::ST_CLEARED;
            state_nxt      = S_OUT;
          end else if (!in_ch.data.has_address) begin
            res_nxt.status         = ksst_pkg::ST_EMPTY;
            res_nxt.overflow_total = dropped_r;
            res_nxt.entries_used   = 6'(used_r);
            state_nxt              = S_OUT;
          end else begin
            head_nxt.valid  = 1'b1;
            head_nxt.key    = in_ch.data.station_address;
            head_nxt.digest = in_ch.data.name_digest;
            head_nxt.auth   = in_ch.data.auth_code;
            head_nxt.chan   = in_ch.data.radio_channel;
            head_nxt.level  = in_ch.data.signal_level;
            head_nxt.used   = used_r;
            head_nxt.done   = 1'b0;
            head_nxt.ins    = 1'b0;
            head_nxt.idx    = '0;
            head_nxt.count  = 16'd0;
            head_nxt.best   = '0;
            state_nxt       = S_BUSY;
          end
        end
      end
      S_BUSY: begin
        if (tail.valid) begin
          res_nxt = '0;
          if (tail.done) begin
            if (tail.ins) begin
              used_nxt = used_r + ksst_pkg::CNT_W'(1);
            end
            res_nxt.accepted     = 1'b1;
            res_nxt.status       = tail.ins ? ksst_pkg::ST_INSERTED : ksst_pkg::ST_UPDATED;
            res_nxt.entry_index  = 5'(tail.idx);
            res_nxt.sample_total = tail.count;
            res_nxt.best_level   = tail.best;
          end else begin
            if (dropped_r != ksst_pkg::COUNT_MAX) begin
              dropped_nxt = dropped_r + 16'd1;
            end
            res_nxt.status = ksst_pkg::ST_FULL;
          end
          res_nxt.overflow_total = dropped_nxt;
          res_nxt.entries_used   = 6'(used_nxt);
          state_nxt              = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      dropped_r    <= 16'd0;
      head_r.valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      dropped_r <= dropped_nxt;
      head_r    <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  `KSST_ASSERT(a_used_in_range, used_r <= ksst_pkg::CNT_W'(ksst_pkg::TABLE_DEPTH))
  `KSST_ASSERT(a_single_probe, $onehot0(probe_vld))
  `KSST_ASSERT(a_tail_when_busy, tail.valid |-> state_r == S_BUSY)
  `KSST_ASSERT(a_update_counts, out_ch.valid && res_r.accepted |-> res_r.sample_total != 16'd0)
  `KSST_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == S_IDLE && !head_r.valid)

endmodule

>>> verif/tb_keyed_station_stats_table_top.sv
// ----------------------------------------------------------------------------
// tb_keyed_station_stats_table_top
// Checks the station statistics table against a predictor that keeps its own
// copy of the table. Each result word is compared field by field with the
// oldest prediction. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_keyed_station_stats_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ksst_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_WORDS = 1190;

  logic clk;
  logic rst_n;

  ksst_in_if  in_ch();
  ksst_out_if out_ch();

  keyed_station_stats_table_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted table contents; only occupied slots are ever read.
  logic [47:0]       ap_address [TABLE_DEPTH];
  logic [31:0]       ap_digest  [TABLE_DEPTH];
  logic [3:0]        ap_auth    [TABLE_DEPTH];
  logic [7:0]        ap_channel [TABLE_DEPTH];
  logic signed [7:0] ap_best    [TABLE_DEPTH];
  logic signed [7:0] ap_last    [TABLE_DEPTH];
  logic [15:0]       ap_samples [TABLE_DEPTH];
  int                slots_used;
  logic [15:0]       dropped_sightings;

  out_word_t expected_reports [$];
  int        mismatches;
  int        cycle_count = 0;
  int        source_quiet;
  int        sink_quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic out_word_t predict_station(input in_word_t w);
    out_word_t r;
    int        hit;
    r   = '0;
    hit = -1;
    if (w.action) begin
      slots_used        = 0;
      dropped_sightings = '0;
      r.status          = ST_CLEARED;
    end else if (!w.has_address) begin
      r.status = ST_EMPTY;
    end else begin
      for (int i = 0; i < slots_used; i++) begin
        if (hit < 0 && ap_address[i] == w.station_address) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        if (ap_samples[hit] != COUNT_MAX) begin
          ap_samples[hit]++;
        end
        ap_last[hit] = w.signal_level;
        if (w.signal_level > ap_best[hit]) begin
          ap_best[hit] = w.signal_level;
        end
        if (w.name_digest != '0) begin
          ap_digest[hit] = w.name_digest;
        end
        if (w.auth_code != '0) begin
          ap_auth[hit] = w.auth_code;
        end
        if (w.radio_channel != '0) begin
          ap_channel[hit] = w.radio_channel;
        end
        r.accepted     = 1'b1;
        r.status       = ST_UPDATED;
        r.entry_index  = 5'(hit);
        r.sample_total = ap_samples[hit];
        r.best_level   = ap_best[hit];
      end else if (slots_used >= TABLE_DEPTH) begin
        if (dropped_sightings != COUNT_MAX) begin
          dropped_sightings++;
        end
        r.status = ST_FULL;
      end else begin
        ap_address[slots_used] = w.station_address;
        ap_digest[slots_used]  = w.name_digest;
        ap_auth[slots_used]    = w.auth_code;
        ap_channel[slots_used] = w.radio_channel;
        ap_best[slots_used]    = w.signal_level;
        ap_last[slots_used]    = w.signal_level;
        ap_samples[slots_used] = 16'd1;
        r.accepted             = 1'b1;
        r.status               = ST_INSERTED;
        r.entry_index          = 5'(slots_used);
        r.sample_total         = 16'd1;
        r.best_level           = w.signal_level;
        slots_used++;
      end
    end
    r.overflow_total = dropped_sightings;
    r.entries_used   = 6'(slots_used);
    return r;
  endfunction

  function automatic logic [47:0] any_address();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[47:0];
  endfunction

  function automatic in_word_t command(input logic act, input logic has_addr);
    in_word_t w;
    w.action          = act;
    w.has_address     = has_addr;
    w.station_address = any_address();
    w.name_digest     = $urandom;
    w.auth_code       = 4'($urandom_range(0, 15));
    w.radio_channel   = 8'($urandom_range(0, 255));
    w.signal_level    = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic in_word_t observation(input logic [47:0] addr, input logic [31:0] digest,
                                           input logic [3:0] auth, input logic [7:0] chan,
                                           input logic [7:0] level);
    in_word_t w;
    w.action          = 1'b0;
    w.has_address     = 1'b1;
    w.station_address = addr;
    w.name_digest     = digest;
    w.auth_code       = auth;
    w.radio_channel   = chan;
    w.signal_level    = level;
    return w;
  endfunction

  // Zero fields are drawn often, since a zero leaves the stored value alone.
  function automatic in_word_t sighting(input logic [47:0] addr);
    logic [31:0] digest;
    logic [3:0]  auth;
    logic [7:0]  chan;
    logic [7:0]  level;
    digest = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
    auth   = ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
    chan   = ($urandom_range(0, 3) == 0) ? 8'h0 : 8'($urandom_range(1, 255));
    case ($urandom_range(0, 9))
      0: begin
        level = 8'h7F;
      end
      1: begin
        level = 8'h80;
      end
      default: begin
        level = 8'($urandom_range(0, 255));
      end
    endcase
    return observation(addr, digest, auth, chan, level);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 40) begin
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic send_word(input in_word_t w);
    int gap;
    gap = draw_gap(source_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    expected_reports.push_back(predict_station(w));
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = draw_gap(sink_quiet);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected result word", out_ch.data, '0);
      end else begin
        want = expected_reports.pop_front();
        if (out_ch.data.accepted !== want.accepted) begin
          report_mismatch("accepted", out_ch.data.accepted, want.accepted);
        end
        if (out_ch.data.status !== want.status) begin
          report_mismatch("status", out_ch.data.status, want.status);
        end
        if (out_ch.data.entry_index !== want.entry_index) begin
          report_mismatch("entry_index", out_ch.data.entry_index, want.entry_index);
        end
        if (out_ch.data.sample_total !== want.sample_total) begin
          report_mismatch("sample_total", out_ch.data.sample_total, want.sample_total);
        end
        if (out_ch.data.best_level !== want.best_level) begin
          report_mismatch("best_level", out_ch.data.best_level, want.best_level);
        end
        if (out_ch.data.overflow_total !== want.overflow_total) begin
          report_mismatch("overflow_total", out_ch.data.overflow_total, want.overflow_total);
        end
        if (out_ch.data.entries_used !== want.entries_used) begin
          report_mismatch("entries_used", out_ch.data.entries_used, want.entries_used);
        end
      end
    end
  end

  task automatic test_edge_values();
    send_word(command(1'b0, 1'b0));
    send_word(observation(48'h0, 32'h0, 4'h0, 8'h00, 8'h80));
    send_word(observation(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 8'hFF, 8'h7F));
    send_word(observation(48'h0, 32'h1234_5678, 4'h5, 8'h06, 8'h7F));
    send_word(observation(48'hFFFF_FFFF_FFFF, 32'h0, 4'h0, 8'h00, 8'h80));
    send_word(observation(48'h0, 32'h0, 4'h0, 8'h00, 8'hFF));
    send_word(observation(48'h0000_0000_0001, 32'h0000_0001, 4'h1, 8'h01, 8'h00));
    send_word(observation(48'h8000_0000_0000, 32'h8000_0000, 4'h8, 8'h80, 8'h01));
    send_word(observation(48'h0000_0000_0001, 32'h0, 4'h0, 8'h00, 8'h01));
    send_word(command(1'b0, 1'b0));
    send_word(command(1'b1, 1'b1));
    send_word(observation(48'hFFFF_FFFF_FFFF, 32'h0, 4'h0, 8'h00, 8'h00));
    send_word(command(1'b1, 1'b0));
    send_word(command(1'b0, 1'b0));
    send_word(sighting(48'h0));
    wait_for_results();
  endtask

  task automatic test_table_full();
    logic [47:0] filled [TABLE_DEPTH];
    logic [47:0] addr;
    send_word(command(1'b1, 1'($urandom_range(0, 1))));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      filled[i]      = any_address();
      filled[i][7:0] = 8'(i);
      send_word(sighting(filled[i]));
    end
    for (int k = 0; k < 3; k++) begin
      addr      = any_address();
      addr[7:0] = 8'hE0 + 8'(k);
      send_word(sighting(addr));
    end
    send_word(sighting(filled[0]));
    send_word(sighting(filled[TABLE_DEPTH-1]));
    send_word(command(1'b0, 1'b0));
    wait_for_results();
    send_word(command(1'b1, 1'($urandom_range(0, 1))));
  endtask

  task automatic test_random_traffic();
    logic [47:0] pool [48];
    int          pool_size;
    int          sent;
    int          pick;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      pool_size = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 48) : $urandom_range(1, 28);
      for (int i = 0; i < pool_size; i++) begin
        pool[i] = ($urandom_range(0, 3) == 0) ? 48'(i) : any_address();
      end
      if ($urandom_range(0, 1) == 0) begin
        send_word(command(1'b1, 1'($urandom_range(0, 1))));
        sent++;
      end
      repeat ($urandom_range(40, 120)) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          send_word(command(1'b1, 1'($urandom_range(0, 1))));
        end else if (pick < 7) begin
          send_word(command(1'b0, 1'b0));
        end else if (pick < 11) begin
          send_word(sighting(any_address()));
        end else begin
          send_word(sighting(pool[$urandom_range(0, pool_size - 1)]));
        end
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_for_results();
      end
    end
  endtask

  initial begin
    mismatches        = 0;
    source_quiet      = 0;
    sink_quiet        = 0;
    slots_used        = 0;
    dropped_sightings = '0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_values();
    test_table_full();
    test_random_traffic();
    wait_for_results();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
